@@ design/bounded_deque_top_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros shared by the bounded deque RTL.
// Both macros sample on the rising edge of clock and are disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_DEQUE_TOP_MACROS_SVH
`define BOUNDED_DEQUE_TOP_MACROS_SVH

// A condition that must hold at every clock edge.
`define BDQ_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// A consequence that must hold in the cycle after the antecedent.
`define BDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/bdq_pkg.sv @@
// ----------------------------------------------------------------------------
// bdq_pkg
// Types and constants shared by the bounded deque modules.
// ----------------------------------------------------------------------------
package bdq_pkg;

   // Storage depth and derived widths.
   localparam int DEPTH  = 16;
   localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int SUM_W  = AW + 1;
   localparam int CAP_W  = 5;
   localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam int WORD_W = 32;

   // Operation codes carried in a request beat.
   typedef enum logic [2:0] {
      KIND_PUSH_FRONT = 3'd0,
      KIND_PUSH_REAR  = 3'd1,
      KIND_POP_FRONT  = 3'd2,
      KIND_POP_REAR   = 3'd3,
      KIND_PEEK_FRONT = 3'd4,
      KIND_PEEK_REAR  = 3'd5
   } kind_type;

   // Status codes carried in a response beat.
   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      kind_type                   kind;
      logic signed [WORD_W-1:0]   value;
   } req_type;

   typedef struct packed {
      status_type                 status;
      logic signed [WORD_W-1:0]   value_out;
   } rsp_type;

   // Memory access issued by the controller.
   typedef struct packed {
      logic                wr_en;
      logic [AW-1:0]       wr_addr;
      logic [WORD_W-1:0]   wr_data;
      logic                rd_en;
      logic [AW-1:0]       rd_addr;
   } mem_cmd_type;

   // Result information that is held in a register until the memory read data arrives.
   typedef struct packed {
      logic        valid;
      status_type  status;
      logic        from_mem;
      logic        neg_one;
   } res_info_type;

endpackage

@@ design/bdq_mem.sv @@
// ----------------------------------------------------------------------------
// bdq_mem
// Word storage of the deque: one write port and one registered read port.
// ----------------------------------------------------------------------------
module bdq_mem import bdq_pkg::*; (
   input  logic                clock,
   input  mem_cmd_type         cmd,
   output logic [WORD_W-1:0]   rd_data
);

   logic [WORD_W-1:0] mem_ff [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem_ff[cmd.wr_addr] <= cmd.wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= mem_ff[cmd.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/bdq_ctrl.sv @@
// ----------------------------------------------------------------------------
// bdq_ctrl
// Head pointer, word count and capacity register; decodes each request beat
// into a memory access and the status of its response.
// ----------------------------------------------------------------------------
`include "bounded_deque_top_macros.svh"

module bdq_ctrl import bdq_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  req_type            req,
   input  logic               csr_we,
   input  logic [CAP_W-1:0]   csr_wdata,
   output mem_cmd_type        cmd,
   output res_info_type       res_in
);

   logic [AW-1:0]     head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CAP_W-1:0]  cap_ff;

   logic [CMP_W-1:0]  eff_cap;
   logic              full;
   logic              empty;
   logic [AW-1:0]     head_dec;
   logic [AW-1:0]     head_inc;
   logic [SUM_W-1:0]  end_sum;
   logic [SUM_W-1:0]  last_sum;
   logic [AW-1:0]     rear_slot;
   logic [AW-1:0]     last_slot;

   // Capacity register, written by the configuration port.
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_W'(16);
      end else if (csr_we) begin
         cap_ff <= csr_wdata;
      end
   end

   // Effective capacity is clamped to 1..DEPTH.
   always_comb begin
      if (cap_ff == '0) begin
         eff_cap = CMP_W'(1);
      end else if (CMP_W'(cap_ff) > CMP_W'(DEPTH)) begin
         eff_cap = CMP_W'(DEPTH);
      end else begin
         eff_cap = CMP_W'(cap_ff);
      end
   end

   assign full  = CMP_W'(count_ff) >= eff_cap;
   assign empty = (count_ff == '0);

   // Circular slot arithmetic; every sum stays below twice the depth.
   assign head_dec = (head_ff == '0) ? AW'(DEPTH - 1) : head_ff - AW'(1);
   assign head_inc = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + AW'(1);
   assign end_sum  = SUM_W'(head_ff) + SUM_W'(count_ff);
   assign last_sum = end_sum - SUM_W'(1);
   assign rear_slot = (end_sum >= SUM_W'(DEPTH)) ?
                      AW'(end_sum - SUM_W'(DEPTH)) : AW'(end_sum);
   assign last_slot = (last_sum >= SUM_W'(DEPTH)) ?
                      AW'(last_sum - SUM_W'(DEPTH)) : AW'(last_sum);

   // Decode of one request beat.
   always_comb begin
      head_in          = head_ff;
      count_in         = count_ff;
      cmd.wr_en        = 1'b0;
      cmd.wr_addr      = head_dec;
      cmd.wr_data      = req.value;
      cmd.rd_en        = 1'b0;
      cmd.rd_addr      = head_ff;
      res_in.valid     = accept;
      res_in.status    = STATUS_OK;
      res_in.from_mem  = 1'b0;
      res_in.neg_one   = 1'b0;
      if (accept) begin
         unique case (req.kind)
            KIND_PUSH_FRONT: begin
               if (full) begin
                  res_in.status = STATUS_FULL;
               end else begin
                  head_in     = head_dec;
                  count_in    = count_ff + CNT_W'(1);
                  cmd.wr_en   = 1'b1;
                  cmd.wr_addr = head_dec;
               end
            end
            KIND_PUSH_REAR: begin
               if (full) begin
                  res_in.status = STATUS_FULL;
               end else begin
                  count_in    = count_ff + CNT_W'(1);
                  cmd.wr_en   = 1'b1;
                  cmd.wr_addr = rear_slot;
               end
            end
            KIND_POP_FRONT: begin
               if (empty) begin
                  res_in.status = STATUS_EMPTY;
               end else begin
                  head_in  = head_inc;
                  count_in = count_ff - CNT_W'(1);
               end
            end
            KIND_POP_REAR: begin
               if (empty) begin
                  res_in.status = STATUS_EMPTY;
               end else begin
                  count_in = count_ff - CNT_W'(1);
               end
            end
            KIND_PEEK_FRONT: begin
               if (empty) begin
                  res_in.status  = STATUS_EMPTY;
                  res_in.neg_one = 1'b1;
               end else begin
                  cmd.rd_en       = 1'b1;
                  cmd.rd_addr     = head_ff;
                  res_in.from_mem = 1'b1;
               end
            end
            KIND_PEEK_REAR: begin
               if (empty) begin
                  res_in.status  = STATUS_EMPTY;
                  res_in.neg_one = 1'b1;
               end else begin
                  cmd.rd_en       = 1'b1;
                  cmd.rd_addr     = last_slot;
                  res_in.from_mem = 1'b1;
               end
            end
            default: begin
               // Unused operation codes do nothing and report ok.
            end
         endcase
      end
   end

   // Pointer and count registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   `BDQ_ASSERT_ALWAYS(a_count_bound, CMP_W'(count_ff) <= CMP_W'(DEPTH), "count exceeds depth")
   `BDQ_ASSERT_ALWAYS(a_one_access, !(cmd.wr_en && cmd.rd_en), "read and write in one beat")
   `BDQ_ASSERT_NEXT(a_idle_hold, !accept, $stable(count_ff) && $stable(head_ff), "state moved while idle")

endmodule

@@ design/bounded_deque_top.sv @@
// A response beat appears in the cycle after its request beat is accepted.
// Throughput: one request beat per cycle; busy stays low, since the single
// memory access of each beat and the pointer update both finish in that cycle.
// Reset: synchronous, active high; the deque empties, head returns to zero and
// capacity returns to 16. Stored words are not cleared and need no clearing pass.
// The receiver cannot stall: each response beat shows for exactly one cycle.
// ----------------------------------------------------------------------------
// bounded_deque_top
// Bounded double-ended queue of signed words, kept in a circular buffer.
// ----------------------------------------------------------------------------
`include "bounded_deque_top_macros.svh"

module bounded_deque_top import bdq_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  req_type            req_payload,
   output logic               rsp_strobe,
   output rsp_type            rsp_payload,
   input  logic               csr_we,
   input  logic [CAP_W-1:0]   csr_wdata
);

   logic               accept;
   mem_cmd_type        cmd;
   res_info_type       res_in;
   res_info_type       res_ff;
   logic [WORD_W-1:0]  rd_data;

   // The deque never holds a request off.
   assign busy   = 1'b0;
   assign accept = start && !busy;

   bdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req_payload),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .res_in    (res_in)
   );

   bdq_mem u_mem (
      .clock   (clock),
      .cmd     (cmd),
      .rd_data (rd_data)
   );

   // Result stage, aligned with the memory read data. Only the valid bit is reset.
   always_ff @(posedge clock) begin
      res_ff.status   <= res_in.status;
      res_ff.from_mem <= res_in.from_mem;
      res_ff.neg_one  <= res_in.neg_one;
      if (reset) begin
         res_ff.valid <= 1'b0;
      end else begin
         res_ff.valid <= res_in.valid;
      end
   end

   // Response beat.
   assign rsp_strobe = res_ff.valid;
   always_comb begin
      rsp_payload.status = res_ff.status;
      if (res_ff.from_mem) begin
         rsp_payload.value_out = rd_data;
      end else if (res_ff.neg_one) begin
         rsp_payload.value_out = '1;
      end else begin
         rsp_payload.value_out = '0;
      end
   end

   `BDQ_ASSERT_NEXT(a_rsp_follows, accept, rsp_strobe, "missing response beat")
   `BDQ_ASSERT_NEXT(a_no_spurious, !accept, !rsp_strobe, "response beat without request")
   `BDQ_ASSERT_ALWAYS(a_src_onehot, $onehot0({res_ff.from_mem, res_ff.neg_one}), "two value sources")

endmodule

@@ sim/bounded_deque_checker.sv @@
// ----------------------------------------------------------------------------
// bounded_deque_checker
// Watches the request, response and register ports of the bounded deque.
// It keeps its own copy of the deque and the capacity setting, predicts the
// response beat of every accepted request beat, and compares the responses
// in order.
// ----------------------------------------------------------------------------
module bounded_deque_checker import bdq_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  req_type            req_payload,
   input  logic               rsp_strobe,
   input  rsp_type            rsp_payload,
   input  logic               csr_we,
   input  logic [CAP_W-1:0]   csr_wdata,
   output int                 fail_count,
   output int                 outstanding,
   output int                 matched,
   output int                 full_hits,
   output int                 empty_hits
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_LIMIT = 10;

   // Shadow copy of the deque.
   logic [WORD_W-1:0]   word_store [DEPTH];
   int                  front_ptr;
   int                  fill_level;
   logic [CAP_W-1:0]    cap_setting;

   // Predicted response beats, oldest first.
   rsp_type             pending_results [$];

   // A written capacity outside 1..DEPTH is clamped into that range.
   function automatic int usable_capacity();
      int c;
      c = int'(cap_setting);
      if (c < 1) begin
         c = 1;
      end
      if (c > DEPTH) begin
         c = DEPTH;
      end
      return c;
   endfunction

   function automatic int slot_of(input int offset);
      return (front_ptr + offset) % DEPTH;
   endfunction

   // Applies one operation to the shadow deque and gives its response.
   task automatic predict_result(input req_type beat, output rsp_type res);
      res.status    = STATUS_OK;
      res.value_out = '0;
      case (beat.kind)
         KIND_PUSH_FRONT: begin
            if (fill_level >= usable_capacity()) begin
               res.status = STATUS_FULL;
            end else begin
               front_ptr = (front_ptr + DEPTH - 1) % DEPTH;
               word_store[front_ptr] = beat.value;
               fill_level++;
            end
         end
         KIND_PUSH_REAR: begin
            if (fill_level >= usable_capacity()) begin
               res.status = STATUS_FULL;
            end else begin
               word_store[slot_of(fill_level)] = beat.value;
               fill_level++;
            end
         end
         KIND_POP_FRONT: begin
            if (fill_level == 0) begin
               res.status = STATUS_EMPTY;
            end else begin
               front_ptr = slot_of(1);
               fill_level--;
            end
         end
         KIND_POP_REAR: begin
            if (fill_level == 0) begin
               res.status = STATUS_EMPTY;
            end else begin
               fill_level--;
            end
         end
         KIND_PEEK_FRONT: begin
            if (fill_level == 0) begin
               res.status    = STATUS_EMPTY;
               res.value_out = '1;
            end else begin
               res.value_out = word_store[slot_of(0)];
            end
         end
         KIND_PEEK_REAR: begin
            if (fill_level == 0) begin
               res.status    = STATUS_EMPTY;
               res.value_out = '1;
            end else begin
               res.value_out = word_store[slot_of(fill_level - 1)];
            end
         end
         default: begin
            // Spare operation codes do nothing and answer ok with zero.
         end
      endcase
   endtask

   task automatic report_mismatch(input string what, input logic [WORD_W-1:0] want,
                                  input logic [WORD_W-1:0] got);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) begin
         $display("%0t: mismatch on %s: expected %h, got %h", $realtime, what, want, got);
      end
   endtask

   // Responses are checked before the request of the same edge is predicted;
   // a response always belongs to an earlier request beat.
   always @(posedge clock) begin : monitor
      rsp_type oldest;
      rsp_type fresh;
      if (reset) begin
         front_ptr   = 0;
         fill_level  = 0;
         cap_setting = 5'd16;
         pending_results.delete();
         fail_count  = 0;
         matched     = 0;
         full_hits   = 0;
         empty_hits  = 0;
      end else begin
         if (rsp_strobe) begin
            if (pending_results.size() == 0) begin
               report_mismatch("unexpected response beat", '0, rsp_payload.value_out);
            end else begin
               oldest = pending_results.pop_front();
               if (rsp_payload.status !== oldest.status) begin
                  report_mismatch("status", oldest.status, rsp_payload.status);
               end else if (rsp_payload.value_out !== oldest.value_out) begin
                  report_mismatch("value_out", oldest.value_out, rsp_payload.value_out);
               end else begin
                  matched++;
                  if (oldest.status == STATUS_FULL) begin
                     full_hits++;
                  end
                  if (oldest.status == STATUS_EMPTY) begin
                     empty_hits++;
                  end
               end
            end
         end
         if (csr_we) begin
            cap_setting = csr_wdata;
         end
         if (start && !busy) begin
            predict_result(req_payload, fresh);
            pending_results.push_back(fresh);
         end
      end
      outstanding = pending_results.size();
   end

endmodule

@@ sim/bounded_deque_top_test.sv @@
// ----------------------------------------------------------------------------
// bounded_deque_top_test
// Drives the bounded deque with a short directed sequence and then with
// random bursts of operations under a series of capacity settings. A
// checker beside the block predicts and compares every response beat.
// ----------------------------------------------------------------------------
module bounded_deque_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import bdq_pkg::*;

   localparam int PHASES        = 12;
   localparam int PHASE_ITEMS   = 120;
   localparam int IDLE_LIMIT    = 1000;
   localparam int SETTLE_CYCLES = 4;

   // Operation codes the block does not define.
   localparam logic [2:0] KIND_SPARE_LO = 3'd6;
   localparam logic [2:0] KIND_SPARE_HI = 3'd7;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   req_type            req_payload;
   logic               rsp_strobe;
   rsp_type            rsp_payload;
   logic               csr_we;
   logic [CAP_W-1:0]   csr_wdata;

   int                 fail_count;
   int                 outstanding;
   int                 matched;
   int                 full_hits;
   int                 empty_hits;

   logic               beat_taken = 1'b0;
   int                 idle_cycles = 0;
   int                 beats_sent = 0;
   int                 cap_writes = 0;

   bounded_deque_top dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata)
   );

   bounded_deque_checker result_check (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .outstanding (outstanding),
      .matched     (matched),
      .full_hits   (full_hits),
      .empty_hits  (empty_hits)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Acceptance flag for the driver, and a watchdog on cycles without a beat.
   always @(posedge clock) begin
      beat_taken <= start && !busy;
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Watchdog: no beat accepted for %0d cycles", idle_cycles);
         $display("Test completed with failures");
         $finish;
      end
   end

   // Holds one request beat from a falling edge until it is accepted.
   task automatic send_beat(input logic [2:0] kind_code, input logic [WORD_W-1:0] word);
      start       <= 1'b1;
      req_payload <= '{kind: kind_type'(kind_code), value: word};
      do @(negedge clock); while (!beat_taken);
      beats_sent++;
   endtask

   // The register is written only once every response beat has come back.
   task automatic write_capacity(input logic [CAP_W-1:0] setting);
      start <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (2) @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= setting;
      @(negedge clock);
      csr_we    <= 1'b0;
      cap_writes++;
   endtask

   // Words lean toward the extremes now and then.
   function automatic logic [WORD_W-1:0] pick_word();
      case ($urandom_range(0, 7))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'hFFFF_FFFF;
         3:       return 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   // A filling burst mostly pushes; a draining burst mostly pops.
   function automatic logic [2:0] pick_kind(input bit filling);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
         return roll[0] ? KIND_SPARE_HI : KIND_SPARE_LO;
      end
      if (filling ? (roll < 63) : (roll < 18)) begin
         return $urandom_range(0, 1) ? KIND_PUSH_REAR : KIND_PUSH_FRONT;
      end
      if (roll < 80) begin
         return $urandom_range(0, 1) ? KIND_POP_REAR : KIND_POP_FRONT;
      end
      return $urandom_range(0, 1) ? KIND_PEEK_REAR : KIND_PEEK_FRONT;
   endfunction

   initial begin
      logic [CAP_W-1:0] cap_plan [PHASES];
      int               left;
      int               burst;
      int               gap;
      bit               filling;

      cap_plan = '{5'd16, 5'd3, 5'd0, 5'd31, 5'd1, 5'd2, 5'd8, 5'd17,
                   5'd0, 5'd0, 5'd0, 5'd15};

      reset       = 1'b1;
      start       = 1'b0;
      req_payload = '0;
      csr_we      = 1'b0;
      csr_wdata   = '0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Everything on an empty deque fails with the empty status.
      send_beat(KIND_PEEK_FRONT, $urandom);
      send_beat(KIND_PEEK_REAR, $urandom);
      send_beat(KIND_POP_FRONT, $urandom);
      send_beat(KIND_POP_REAR, $urandom);

      // Extreme words at both ends, the spare codes, then further pushes, pops and peeks.
      send_beat(KIND_PUSH_FRONT, 32'h7FFF_FFFF);
      send_beat(KIND_PUSH_REAR, 32'h8000_0000);
      send_beat(KIND_PEEK_FRONT, $urandom);
      send_beat(KIND_PEEK_REAR, $urandom);
      send_beat(KIND_SPARE_LO, $urandom);
      send_beat(KIND_SPARE_HI, 32'hFFFF_FFFF);
      send_beat(KIND_PUSH_FRONT, 32'hFFFF_FFFF);
      send_beat(KIND_POP_REAR, $urandom);
      send_beat(KIND_PEEK_REAR, $urandom);
      send_beat(KIND_POP_FRONT, $urandom);
      send_beat(KIND_PEEK_FRONT, $urandom);

      // A written zero acts as a capacity of one; one word is already stored, so the push is refused as full.
      write_capacity(5'd0);
      send_beat(KIND_PUSH_REAR, 32'h0000_0000);
      send_beat(KIND_PEEK_REAR, $urandom);

      // Capacity two: one push fills it and two more pushes are refused as full.
      write_capacity(5'd2);
      send_beat(KIND_PUSH_REAR, 32'h5555_5555);
      send_beat(KIND_PUSH_FRONT, 32'hAAAA_AAAA);
      send_beat(KIND_PUSH_REAR, $urandom);

      // Capacity lowered below the stored count keeps the words.
      write_capacity(5'd1);
      send_beat(KIND_PUSH_FRONT, $urandom);
      send_beat(KIND_POP_FRONT, $urandom);
      send_beat(KIND_PUSH_REAR, $urandom);
      send_beat(KIND_POP_REAR, $urandom);
      send_beat(KIND_PUSH_REAR, $urandom);

      // Random bursts, one capacity setting per phase; the deque carries over.
      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase >= 8 && phase <= 10) begin
            cap_plan[phase] = CAP_W'($urandom_range(1, 16));
         end
         write_capacity(cap_plan[phase]);
         left = PHASE_ITEMS;
         while (left > 0) begin
            burst = $urandom_range(1, 24);
            if (burst > left) begin
               burst = left;
            end
            filling = 1'($urandom_range(0, 1));
            repeat (burst) send_beat(pick_kind(filling), pick_word());
            left -= burst;
            gap = (phase % 4 == 1 || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
               start <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
      end

      // Drain the last response beats and let the block settle.
      start <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("Run covered %0d request beats under %0d capacity writes; %0d responses matched.",
               beats_sent, cap_writes, matched);
      $display("Responses with full status: %0d, with empty status: %0d, mismatches: %0d.",
               full_hits, empty_hits, fail_count);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+design
design/bdq_pkg.sv
design/bdq_mem.sv
design/bdq_ctrl.sv
design/bounded_deque_top.sv
sim/bounded_deque_checker.sv
sim/bounded_deque_top_test.sv
